### rtl/mpi_pkg.sv
// ----------------------------------------------------------------------------
// mpi_pkg: shared types and constants for modular power and inverse
// Holds the request/response structs and the operand width default.
// ----------------------------------------------------------------------------
`default_nettype none
package mpi_pkg;
   localparam int OperandBits = 31;

   localparam logic CmdPower   = 1'b0;
   localparam logic CmdInverse = 1'b1;

   typedef struct packed {
      logic                   cmd;
      logic [OperandBits-1:0] base;
      logic [OperandBits-1:0] exponent;
      logic [OperandBits-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [OperandBits-1:0] result;
      logic                   no_inverse;
   } rsp_type;

   // control between sequencer and shared unit
   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } unit_ctl_type;

   localparam logic [1:0] OpMul = 2'd0;
   localparam logic [1:0] OpRem = 2'd1;
endpackage
`default_nettype wire

### rtl/mpi_unit.sv
// ----------------------------------------------------------------------------
// mpi_unit: shared bit-serial modular arithmetic unit
// OpMul: (a*b) mod m by shift-and-add, one bit of b per cycle.
// OpRem: a mod b by restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mpi_unit #(
   parameter int OPERAND_BITS = mpi_pkg::OperandBits
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mpi_pkg::unit_ctl_type     ctl,
   input  wire logic [OPERAND_BITS-1:0]   opa,
   input  wire logic [OPERAND_BITS-1:0]   opb,
   input  wire logic [OPERAND_BITS-1:0]   opm,
   output logic                           done,
   output logic [OPERAND_BITS-1:0]        value
);
   import mpi_pkg::*;

   localparam int CntBits = $clog2(OPERAND_BITS + 1);

   logic                    busy_ff, busy_in;
   logic                    rem_ff, rem_in;
   logic [CntBits-1:0]      cnt_ff, cnt_in;
   logic [OPERAND_BITS-1:0] a_ff, a_in, b_ff, b_in, m_ff, m_in, r_ff, r_in;
   logic                    done_ff, done_in;

   logic [OPERAND_BITS:0]   dbl, dbl_red, add, shift;

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      done_in = 1'b0;
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      add     = dbl_red[OPERAND_BITS-1:0] + {1'b0, a_ff};
      shift   = {r_ff, b_ff[OPERAND_BITS-1]};
      if (!busy_ff && ctl.start) begin
         // load operands
         busy_in = 1'b1;
         rem_in  = (ctl.op == OpRem);
         cnt_in  = CntBits'(OPERAND_BITS);
         a_in    = opa;
         b_in    = (ctl.op == OpRem) ? opa : opb;
         m_in    = (ctl.op == OpRem) ? opb : opm;
         r_in    = '0;
      end else if (busy_ff) begin
         if (rem_ff) begin
            // restoring division step
            r_in = (shift >= {1'b0, m_ff}) ? OPERAND_BITS'(shift - {1'b0, m_ff})
                                           : OPERAND_BITS'(shift);
         end else if (b_ff[OPERAND_BITS-1]) begin
            r_in = (add >= {1'b0, m_ff}) ? OPERAND_BITS'(add - {1'b0, m_ff})
                                         : OPERAND_BITS'(add);
         end else begin
            r_in = dbl_red[OPERAND_BITS-1:0];
         end
         b_in   = {b_ff[OPERAND_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      r_ff   <= r_in;
   end

   assign done  = done_ff;
   assign value = r_ff;
endmodule
`default_nettype wire

### rtl/modular_power_and_inverse.sv
// ----------------------------------------------------------------------------
// modular_power_and_inverse: base^exponent mod modulus, or Fermat inverse
// Sequencer around one shared bit-serial multiply/remainder unit.
// ----------------------------------------------------------------------------
// Sequence: a power is one reduction of the base, then a modular multiply per
//   set exponent bit and a square per exponent bit (up to 2*OPERAND_BITS
//   multiplies); an inverse first runs one remainder per Euclid step.
// Throughput: one request at a time; busy is high from start until rsp_valid.
// The result strobe is not stalled by the receiver.
// Reset: synchronous, clears the sequencer; no clearing pass needed.
`default_nettype none
module modular_power_and_inverse #(
   parameter int OPERAND_BITS = mpi_pkg::OperandBits
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire mpi_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output mpi_pkg::rsp_type       rsp_data
);
   import mpi_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RED, S_REDW, S_GCD, S_GCDW, S_CHK, S_MUL, S_MULW, S_SQ, S_SQW, S_OUT
   } state_type;

   localparam logic [OPERAND_BITS-1:0] One = OPERAND_BITS'(1);

   state_type               state_ff;
   logic                    cmd_ff;
   logic [OPERAND_BITS-1:0] x_ff, e_ff, m_ff, acc_ff, ga_ff, gb_ff, base_ff;
   logic                    flag_ff;
   logic                    valid_ff;
   unit_ctl_type            ctl;
   logic [OPERAND_BITS-1:0] opa, opb;
   logic                    u_done;
   logic [OPERAND_BITS-1:0] u_val;

   mpi_unit #(.OPERAND_BITS(OPERAND_BITS)) u_unit (
      .clock(clock), .reset(reset), .ctl(ctl), .opa(opa), .opb(opb),
      .opm(m_ff), .done(u_done), .value(u_val)
   );

   // drive the shared unit from the current state
   always_comb begin
      ctl.start = 1'b0;
      ctl.op    = OpMul;
      opa       = acc_ff;
      opb       = x_ff;
      unique case (state_ff)
         S_RED: begin
            ctl.start = 1'b1; ctl.op = OpRem; opa = base_ff; opb = m_ff;
         end
         S_GCD: begin
            ctl.start = (ga_ff != '0); ctl.op = OpRem; opa = gb_ff; opb = ga_ff;
         end
         S_MUL: begin
            ctl.start = e_ff[0];
         end
         S_SQ: begin
            ctl.start = 1'b1; opa = x_ff;
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= (state_ff == S_OUT);
         unique case (state_ff)
            S_IDLE: if (start) begin
               cmd_ff  <= req_data.cmd;
               base_ff <= OPERAND_BITS'(req_data.base);
               m_ff    <= (req_data.modulus == '0) ? One : OPERAND_BITS'(req_data.modulus);
               e_ff    <= OPERAND_BITS'(req_data.exponent);
               ga_ff   <= OPERAND_BITS'(req_data.base);
               gb_ff   <= (req_data.modulus == '0) ? One : OPERAND_BITS'(req_data.modulus);
               flag_ff <= 1'b0;
               state_ff <= (req_data.cmd == CmdInverse) ? S_GCD : S_RED;
            end
            S_GCD: state_ff <= (ga_ff == '0) ? S_CHK : S_GCDW;
            S_GCDW: if (u_done) begin
               // advance Euclid: (a, b) <- (b mod a, a)
               gb_ff    <= ga_ff;
               ga_ff    <= u_val;
               state_ff <= S_GCD;
            end
            S_CHK: begin
               e_ff <= m_ff - OPERAND_BITS'(2);
               if (gb_ff != One) begin
                  flag_ff  <= 1'b1;
                  acc_ff   <= '0;
                  state_ff <= S_OUT;
               end else if (m_ff < OPERAND_BITS'(2)) begin
                  acc_ff   <= '0;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_RED;
               end
            end
            S_RED: state_ff <= S_REDW;
            S_REDW: if (u_done) begin
               x_ff <= u_val;
               // a base that reduces to zero gives zero
               if (u_val == '0) begin
                  acc_ff   <= '0;
                  state_ff <= S_OUT;
               end else begin
                  acc_ff   <= One;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (e_ff == '0) state_ff <= S_OUT;
               else if (e_ff[0]) state_ff <= S_MULW;
               else state_ff <= S_SQ;
            end
            S_MULW: if (u_done) begin
               acc_ff   <= u_val;
               state_ff <= S_SQ;
            end
            S_SQ: state_ff <= S_SQW;
            S_SQW: if (u_done) begin
               // drop the used exponent bit
               x_ff     <= u_val;
               e_ff     <= e_ff >> 1;
               state_ff <= S_MUL;
            end
            S_OUT: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = valid_ff;
   assign rsp_data.result     = acc_ff;
   assign rsp_data.no_inverse = flag_ff;
endmodule
`default_nettype wire

### dv/modular_power_and_inverse_checker.sv
// ----------------------------------------------------------------------------
// Modular power and inverse checker
// Watches the request and response channels, predicts each response from the
// accepted request and compares it field by field, counting failures.
// ----------------------------------------------------------------------------
module modular_power_and_inverse_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  mpi_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  mpi_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_count
);
   import mpi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type pending_rsp_q[$];

   // exact (a * b) mod m on double-width products
   function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] p;
      p = a * b;
      return 64'(p % m);
   endfunction

   function automatic logic [63:0] pow_mod(logic [63:0] x, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      acc = 1 % m;
      x = x % m;
      if (x == 0) return 0;
      while (e != 0) begin
         if (e[0]) acc = mul_mod(acc, x, m);
         e = e >> 1;
         x = mul_mod(x, x, m);
      end
      return acc;
   endfunction

   function automatic logic [63:0] gcd_of(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (a != 0) begin
         t = b % a;
         b = a;
         a = t;
      end
      return b;
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type     o;
      logic [63:0] m;
      o = '0;
      m = (r.modulus == 0) ? 64'd1 : 64'(r.modulus);
      if (r.cmd == CmdPower)
         o.result = OperandBits'(pow_mod(64'(r.base), 64'(r.exponent), m));
      else if (gcd_of(64'(r.base), m) != 1)
         o.no_inverse = 1'b1;
      else if (m >= 2)
         o.result = OperandBits'(pow_mod(64'(r.base), m - 2, m));
      return o;
   endfunction

   assign pending_count = pending_rsp_q.size();

   // queue predictions at request accept; compare at response strobe
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
         rsp_count  <= 0;
      end else begin
         if (start && !busy) pending_rsp_q = {pending_rsp_q, predict_rsp(req_data)};
         if (rsp_valid) begin
            rsp_count <= rsp_count + 1;
            if (pending_rsp_q.size() == 0) begin
               $display("%0t: unexpected response result=%0d no_inverse=%0d",
                        $realtime, rsp_data.result, rsp_data.no_inverse);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_rsp_q.pop_front();
               if (want.result !== rsp_data.result ||
                   want.no_inverse !== rsp_data.no_inverse) begin
                  $display("%0t: mismatch expected result=%0d no_inverse=%0d, got %0d %0d",
                           $realtime, want.result, want.no_inverse,
                           rsp_data.result, rsp_data.no_inverse);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### dv/modular_power_and_inverse_tb.sv
// ----------------------------------------------------------------------------
// Modular power and inverse testbench
// Drives directed and random power/inverse requests in bursts with gaps;
// the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module modular_power_and_inverse_tb;
   import mpi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 40000;
   localparam int RandomCount   = 121;
   localparam logic [30:0] MaxOp = 31'h7fffffff;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count, pending_count, rsp_count;
   int      idle_cycles;
   int      request_count;
   int      inverse_count;

   modular_power_and_inverse dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   modular_power_and_inverse_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .rsp_count(rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // count cycles with no accepted request or response
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // hold the request until accepted, then drop start for a cycle
   task automatic send_request(logic cmd, logic [30:0] b, logic [30:0] e, logic [30:0] m);
      start              <= 1'b1;
      req_data.cmd       <= cmd;
      req_data.base      <= b;
      req_data.exponent  <= e;
      req_data.modulus   <= m;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      request_count++;
      if (cmd == CmdInverse) inverse_count++;
      @(posedge clock);
   endtask

   function automatic logic [30:0] rand_op();
      case ($urandom_range(0, 3))
         0: return 31'($urandom_range(0, 20));
         1: return MaxOp - 31'($urandom_range(0, 20));
         default: return 31'($urandom);
      endcase
   endfunction

   initial begin
      int burst;
      logic [30:0] m;
      idle_cycles = 0;
      request_count = 0;
      inverse_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes and special cases
      send_request(CmdPower, 31'd0, 31'd0, 31'd7);
      send_request(CmdPower, 31'd14, 31'd0, 31'd7);
      send_request(CmdPower, 31'd3, 31'd0, 31'd7);
      send_request(CmdPower, 31'd5, MaxOp, 31'd1);
      send_request(CmdPower, 31'd5, 31'd3, 31'd0);
      send_request(CmdInverse, 31'd5, 31'd0, 31'd0);
      send_request(CmdInverse, 31'd5, 31'd0, 31'd1);
      send_request(CmdInverse, 31'd4, 31'd0, 31'd8);
      send_request(CmdInverse, 31'd0, 31'd0, 31'd13);
      send_request(CmdInverse, 31'd3, 31'd0, 31'd13);
      send_request(CmdInverse, 31'd2, MaxOp, MaxOp);
      send_request(CmdInverse, MaxOp - 1, 31'd0, MaxOp);
      send_request(CmdPower, MaxOp, MaxOp, MaxOp);
      send_request(CmdPower, MaxOp - 1, MaxOp, MaxOp);
      send_request(CmdPower, MaxOp, MaxOp, MaxOp - 1);
      send_request(CmdPower, 31'd2, 31'd30, MaxOp);
      send_request(CmdInverse, 31'd12345, 31'h2aaaaaaa, 31'd65537);
      send_request(CmdPower, 31'h55555555, 31'h2aaaaaaa, 31'h40000000);
      send_request(CmdPower, 31'd1, 31'd0, 31'd2);

      // random requests in bursts with gaps, sometimes none
      while (request_count < 19 + RandomCount) begin
         burst = $urandom_range(1, 8);
         repeat (burst) begin
            m = rand_op();
            if ($urandom_range(0, 9) == 0) m = 31'($urandom_range(0, 2));
            send_request(1'($urandom), rand_op(), rand_op(), m);
         end
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(posedge clock);
      end

      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d requests (%0d inverse), %0d responses checked.",
               request_count, inverse_count, rsp_count);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
